### rtl/thw_pkg.sv
// types and constants shared by the tar header walker modules
package thw_pkg;

  localparam int BLOCK_BYTES = 512;

  localparam logic [8:0] LAST_POS    = 9'(BLOCK_BYTES - 1);
  localparam logic [8:0] NAME_END    = 9'd100;
  localparam logic [8:0] SIZE_FIRST  = 9'd124;
  localparam logic [8:0] SIZE_END    = 9'd136;
  localparam logic [8:0] TYPE_POS    = 9'd156;
  localparam logic [8:0] MAGIC_FIRST = 9'd257;
  localparam logic [8:0] MAGIC_LAST  = 9'd261;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_END      = 3'd2;
  localparam logic [2:0] ST_BADMAGIC = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  localparam int CFG_W   = 9;
  localparam int TDATA_W = 88;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } thw_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic [31:0] data_offset;
    logic [31:0] file_size;
    logic [7:0]  type_flag;
    logic [6:0]  name_length;
    logic        needs_slash;
  } thw_result_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/thw_in_stage.sv
// input register for archive words
module thw_in_stage import thw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic [7:0] s_tdata,
  input  logic      s_tlast,
  input  logic      advance,
  output logic      item_valid,
  output thw_item_t item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte <= s_tdata;
      item.last_byte <= s_tlast;
    end
  end

endmodule

### rtl/thw_walker.sv
// header walk state and per-word next-state logic
module thw_walker import thw_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             go,
  input  thw_item_t        item,
  output logic             res_valid,
  output thw_result_t      res
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CFG_W-1:0] DEPTH_LIM = CFG_W'(TABLE_DEPTH);

  logic [CFG_W-1:0] max_entries;
  logic [1:0]       phase, phase_next;
  logic [8:0]       hpos, hpos_next;
  logic [32:0]      skip, skip_next;
  logic [31:0]      size_acc, size_acc_next;
  logic             size_ended, size_ended_next;
  logic             magic_ok, magic_ok_next;
  logic [7:0]       held_type, held_type_next;
  logic [6:0]       name_len, name_len_next;
  logic             name_ended, name_ended_next;
  logic             held_slash, held_slash_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [31:0]      arch_off, arch_off_next;
  logic [31:0]      hdr_start, hdr_start_next;

  logic [7:0]       b;
  logic [32:0]      skip_dec;
  logic [32:0]      skip_new;
  logic             magic_now;
  logic             clear_hdr;
  logic [CFG_W-1:0] limit;

  assign b = item.data_byte;
  assign limit = (max_entries < DEPTH_LIM) ? max_entries : DEPTH_LIM;
  assign skip_dec = (skip != '0) ? skip - 33'd1 : skip;
  assign skip_new = ({1'b0, size_acc} + 33'(LAST_POS)) & ~33'(LAST_POS);
  assign magic_now = magic_ok &&
    !(hpos >= MAGIC_FIRST && hpos <= MAGIC_LAST &&
      b != magic_char(3'(hpos - MAGIC_FIRST)));

  always_comb begin
    phase_next       = phase;
    hpos_next        = hpos;
    skip_next        = skip;
    size_acc_next    = size_acc;
    size_ended_next  = size_ended;
    magic_ok_next    = magic_ok;
    held_type_next   = held_type;
    name_len_next    = name_len;
    name_ended_next  = name_ended;
    held_slash_next  = held_slash;
    entry_count_next = entry_count;
    arch_off_next    = arch_off;
    hdr_start_next   = hdr_start;
    clear_hdr        = 1'b0;
    res_valid        = 1'b0;
    res              = '0;

    if (go) begin
      arch_off_next = arch_off + 32'd1;
      case (phase)
        PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_HEADER;
            clear_hdr  = 1'b1;
          end else if (item.last_byte) begin
            res_valid  = 1'b1;
            res.status = ST_TRUNC;
          end
        end
        PH_HEADER: begin
          if (hpos == '0) begin
            hdr_start_next = arch_off;
          end
          if (hpos == '0 && b == CH_NUL) begin
            res_valid  = 1'b1;
            res.status = ST_END;
            phase_next = PH_HALT;
          end else begin
            if (hpos == '0) begin
              held_slash_next = (b != CH_SLASH);
            end
            if (hpos < NAME_END && !name_ended) begin
              if (b == CH_NUL) begin
                name_ended_next = 1'b1;
              end else begin
                name_len_next = name_len + 7'd1;
              end
            end
            if (hpos >= SIZE_FIRST && hpos < SIZE_END && !size_ended) begin
              if (b == CH_NUL || b == CH_SPACE) begin
                size_ended_next = 1'b1;
              end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
                size_acc_next = {size_acc[28:0], b[2:0]};
              end
            end
            if (hpos == TYPE_POS) begin
              held_type_next = b;
            end
            magic_ok_next = magic_now;

            if (hpos == MAGIC_LAST && !magic_now) begin
              res_valid  = 1'b1;
              res.status = ST_BADMAGIC;
              phase_next = PH_HALT;
            end else if (hpos == LAST_POS) begin
              res_valid = 1'b1;
              skip_next = skip_new;
              if (item.last_byte && skip_new != '0) begin
                res.status = ST_TRUNC;
              end else begin
                if (CFG_W'(entry_count) < limit) begin
                  res.status       = ST_STORED;
                  res.entry_index  = 8'(entry_count);
                  entry_count_next = entry_count + CNT_W'(1);
                end else begin
                  res.status = ST_FULL;
                end
                res.data_offset = hdr_start + 32'(BLOCK_BYTES);
                res.file_size   = size_acc;
                res.type_flag   = held_type;
                res.name_length = name_len;
                res.needs_slash = held_slash;
              end
              if (skip_new != '0) begin
                phase_next = PH_SKIP;
              end else begin
                clear_hdr = 1'b1;
              end
            end else begin
              hpos_next = hpos + 9'd1;
              if (item.last_byte) begin
                res_valid  = 1'b1;
                res.status = ST_TRUNC;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (item.last_byte) begin
        phase_next     = PH_HEADER;
        skip_next      = '0;
        arch_off_next  = '0;
        hdr_start_next = '0;
        clear_hdr      = 1'b1;
      end
      if (clear_hdr) begin
        hpos_next       = '0;
        size_acc_next   = '0;
        size_ended_next = 1'b0;
        magic_ok_next   = 1'b1;
        held_type_next  = '0;
        name_len_next   = '0;
        name_ended_next = 1'b0;
        held_slash_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= CFG_W'(256);
      phase       <= PH_HEADER;
      hpos        <= '0;
      skip        <= '0;
      size_acc    <= '0;
      size_ended  <= 1'b0;
      magic_ok    <= 1'b1;
      held_type   <= '0;
      name_len    <= '0;
      name_ended  <= 1'b0;
      held_slash  <= 1'b0;
      entry_count <= '0;
      arch_off    <= '0;
      hdr_start   <= '0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
      phase       <= phase_next;
      hpos        <= hpos_next;
      skip        <= skip_next;
      size_acc    <= size_acc_next;
      size_ended  <= size_ended_next;
      magic_ok    <= magic_ok_next;
      held_type   <= held_type_next;
      name_len    <= name_len_next;
      name_ended  <= name_ended_next;
      held_slash  <= held_slash_next;
      entry_count <= entry_count_next;
      arch_off    <= arch_off_next;
      hdr_start   <= hdr_start_next;
    end
  end

endmodule

### rtl/thw_out_stage.sv
// result register driving the output stream
module thw_out_stage import thw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  thw_result_t        res,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic [2:0]         m_tuser,
  output logic               advance
);

  thw_result_t held;

  assign advance = !m_tvalid || m_tready;
  assign m_tuser = held.status;
  assign m_tdata = {held.needs_slash, held.name_length, held.type_flag,
                    held.file_size, held.data_offset, held.entry_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

### rtl/tar_header_walker.sv
// top level of the ustar header walker
// path: an archive word is held in the input register, and the result word it causes is held in the result register
// throughput: one archive word per cycle, stalled only while a result waits on m_tready
// reset: rst clears all walk state, the entry count and the result valid flag,
// and sets max_entries to 256; no clearing pass, words are taken on the next cycle
module tar_header_walker import thw_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // entry_index, data_offset, file_size,
                                        // type_flag, name_length, needs_slash
  output logic [2:0]         m_tuser,   // status
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic        advance;
  logic        item_valid;
  thw_item_t   item;
  logic        go;
  logic        res_valid;
  thw_result_t res;

  assign cfg_ready = 1'b1;
  assign go = item_valid && advance;

  thw_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  thw_walker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .go        (go),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  thw_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (go && res_valid),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .advance  (advance)
  );

endmodule

### rtl/thw_checker.sv
// port checks for the tar header walker and their binding
module thw_checker import thw_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [2:0]         m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_simple_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_END || m_tuser == ST_BADMAGIC || m_tuser == ST_TRUNC)
    |-> m_tdata == '0)
    else $error("non-entry word carries payload");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[7:0] == 8'd0)
    else $error("unstored entry has an index");

  a_offset_aligned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_STORED || m_tuser == ST_FULL) |-> m_tdata[16:8] == 9'd0)
    else $error("data offset not block aligned");

  a_name_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_STORED || m_tuser == ST_FULL) |-> m_tdata[86:80] <= 7'd100)
    else $error("name length above clamp");

endmodule

bind tar_header_walker thw_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
